// ===== hw/rtl/mks_pkg.sv =====
// Package for the matrix keypad scanner: word layouts, register indexes,
// command codes and the key map. No dependencies.
package mks_pkg;

    localparam int KEY_W   = 8;
    localparam int CFG_W   = 8;
    localparam int COL_DRV = 4;
    localparam int ROW_IN  = 4;
    localparam int IN_DW   = 8;
    localparam int OUT_DW  = 16;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TIMEOUT = 2'd0;
    localparam t_cfg_idx CFG_SETTLE  = 2'd1;
    localparam t_cfg_idx CFG_GAP     = 2'd2;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [CFG_W-1:0] SETTLE_RESET = 8'd20;
    localparam logic [CFG_W-1:0] GAP_RESET    = 8'd5;
    localparam logic [CFG_W-1:0] CNT_MAX      = 8'd255;

    localparam logic [KEY_W-1:0] KEY_NONE     = 8'd0;
    localparam logic [KEY_W-1:0] KEY_TIMEOUT  = 8'd255;
    localparam logic [KEY_W-1:0] KEY_UNMAPPED = 8'h3F;

    localparam logic [KEY_W-1:0] KEY_MAP [4][4] = '{
        '{8'h31, 8'h34, 8'h37, 8'h2A},
        '{8'h32, 8'h35, 8'h38, 8'h30},
        '{8'h33, 8'h36, 8'h39, 8'h23},
        '{8'h41, 8'h42, 8'h43, 8'h44}
    };

    function automatic logic [KEY_W-1:0] code_at(logic [3:0] col, logic [3:0] row);
        logic [KEY_W-1:0] code;
        if (col < 4'd4 && row < 4'd4) begin
            code = KEY_MAP[col[1:0]][row[1:0]];
        end else begin
            code = KEY_UNMAPPED;
        end
        return code;
    endfunction

endpackage

// ===== hw/rtl/matrix_keypad_scanner_core.sv =====
// Matrix keypad scanner top level: scan sequencer, config registers and
// a two-word output buffer. Depends on mks_pkg.
//
// Each input word is a 1 ms tick carrying the sampled row lines, or a start
// command. One result word comes back for every input word, one input word
// per clock unless stalled: the sequencer state advances by one step at the
// accepting edge and the result is registered straight away. s_axis_tready
// falls only when both output register and skid stage hold untaken words.
module matrix_keypad_scanner_core #(
    parameter int NUM_COLUMNS = 4,
    parameter int NUM_ROWS    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [mks_pkg::IN_DW-1:0]   s_axis_tdata,  // row_lines[3:0], zero pad
    input  logic                        s_axis_tuser,  // command
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // column_drive[3:0], busy_res[4], done_res[5], key_code[13:6], zero pad
    output logic [mks_pkg::OUT_DW-1:0]  m_axis_tdata,
    input  logic                        i_cfg_we,
    input  mks_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [mks_pkg::CFG_W-1:0]   i_cfg_data
);
    import mks_pkg::*;

    localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(NUM_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);

    typedef enum logic [1:0] {
        PH_SETTLE  = 2'd0,
        PH_CHECK   = 2'd1,
        PH_RELEASE = 2'd2,
        PH_GAP     = 2'd3
    } t_phase;

    logic [CFG_W-1:0] r_timeout, r_settle, r_gap;

    logic             r_searching, n_searching;
    t_phase           r_phase, n_phase;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CFG_W-1:0] r_tick, n_tick;
    logic [CFG_W-1:0] r_elapsed, n_elapsed;
    logic [KEY_W-1:0] r_found, n_found;

    logic             accept, out_take;
    logic             cmd;
    logic [ROW_IN-1:0] rows;
    logic [3:0]       row_ext, col_ext, n_col_ext;
    logic             pressed;
    logic [CFG_W-1:0] tick_inc;
    logic [CFG_W:0]   gap_sum;
    logic [CFG_W-1:0] elapsed_sat;
    logic             done;
    logic [KEY_W-1:0] result;
    logic [COL_DRV-1:0] col_drive;
    logic [OUT_DW-1:0] res_word;

    logic              r_m_valid, r_skid_valid;
    logic [OUT_DW-1:0] r_m_data, r_skid_data;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_take = r_m_valid && m_axis_tready;
    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign cmd      = s_axis_tuser;
    assign rows     = s_axis_tdata[ROW_IN-1:0];
    assign row_ext  = 4'(r_row);
    assign col_ext  = 4'(r_col);
    assign pressed  = (row_ext < 4'd4) && !rows[row_ext[1:0]];
    assign tick_inc = (r_tick < CNT_MAX) ? r_tick + 1'b1 : r_tick;
    assign gap_sum  = {1'b0, r_elapsed} + {1'b0, r_gap};
    assign elapsed_sat = gap_sum[CFG_W] ? CNT_MAX : gap_sum[CFG_W-1:0];

    always_comb begin
        n_searching = r_searching;
        n_phase     = r_phase;
        n_col       = r_col;
        n_row       = r_row;
        n_tick      = r_tick;
        n_elapsed   = r_elapsed;
        n_found     = r_found;
        done        = 1'b0;
        result      = KEY_NONE;
        if (cmd == CMD_START) begin
            n_searching = 1'b1;
            n_elapsed   = '0;
            n_found     = KEY_NONE;
            n_col       = '0;
            n_row       = '0;
            n_tick      = '0;
            n_phase     = PH_SETTLE;
        end else if (r_searching) begin
            unique case (r_phase)
                PH_SETTLE: begin
                    n_tick = tick_inc;
                    if (tick_inc >= r_settle) begin
                        n_tick  = '0;
                        n_row   = '0;
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK, PH_RELEASE: begin
                    if (r_phase == PH_CHECK && pressed) begin
                        n_phase = PH_RELEASE;
                    end else if (r_phase == PH_CHECK || !pressed) begin
                        if (r_phase == PH_RELEASE) begin
                            n_found = code_at(col_ext, row_ext);
                        end
                        if (r_row != ROW_LAST) begin
                            n_row   = r_row + 1'b1;
                            n_phase = PH_CHECK;
                        end else if (r_col != COL_LAST) begin
                            n_col   = r_col + 1'b1;
                            n_row   = '0;
                            n_tick  = '0;
                            n_phase = PH_SETTLE;
                        end else begin
                            n_tick  = '0;
                            n_phase = PH_GAP;
                        end
                    end
                end
                PH_GAP: begin
                    n_tick = tick_inc;
                    if (tick_inc >= r_gap) begin
                        n_elapsed = elapsed_sat;
                        if (r_found != KEY_NONE) begin
                            done   = 1'b1;
                            result = r_found;
                        end else if (r_timeout != '0 && elapsed_sat >= r_timeout) begin
                            done   = 1'b1;
                            result = KEY_TIMEOUT;
                        end
                        if (done) begin
                            n_searching = 1'b0;
                        end
                        n_col   = '0;
                        n_row   = '0;
                        n_tick  = '0;
                        n_phase = PH_SETTLE;
                    end
                end
                default: n_phase = PH_SETTLE;
            endcase
        end
    end

    assign n_col_ext = 4'(n_col);
    assign col_drive = (n_searching && n_col_ext < 4'd4)
                     ? ~(4'b0001 << n_col_ext[1:0]) : 4'hF;
    assign res_word  = {2'b00, result, done, n_searching, col_drive};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= '0;
            r_settle    <= SETTLE_RESET;
            r_gap       <= GAP_RESET;
            r_searching <= 1'b0;
            r_phase     <= PH_SETTLE;
            r_col       <= '0;
            r_row       <= '0;
            r_tick      <= '0;
            r_elapsed   <= '0;
            r_found     <= KEY_NONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    CFG_SETTLE:  r_settle  <= i_cfg_data;
                    CFG_GAP:     r_gap     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_searching <= n_searching;
                r_phase     <= n_phase;
                r_col       <= n_col;
                r_row       <= n_row;
                r_tick      <= n_tick;
                r_elapsed   <= n_elapsed;
                r_found     <= n_found;
            end
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept && (!r_m_valid || out_take)) begin
                r_m_valid <= 1'b1;
                r_m_data  <= res_word;
            end else if (accept) begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= res_word;
            end else if (out_take) begin
                if (r_skid_valid) begin
                    r_m_data     <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_m_valid <= 1'b0;
                end
            end
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_m_valid)
        else $error("skid word held with output register empty");

    a_idle_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_searching |-> (r_phase == PH_SETTLE && r_col == '0 && r_row == '0))
        else $error("sequencer not parked while idle");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[5]) |-> !r_m_data[4])
        else $error("done word reports busy");

    a_start_searches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == CMD_START) |=> (r_searching && r_elapsed == '0))
        else $error("start command did not begin a search");

endmodule

// ===== tb/matrix_keypad_scanner_core_tb.sv =====
// Testbench for matrix_keypad_scanner_core: drives tick and start words, predicts
// every result word from its own model of the scan sequencer and checks it.
// Depends on mks_pkg and the core.
module matrix_keypad_scanner_core_tb;
    import mks_pkg::*;

    localparam int SCAN_COLS = 4;
    localparam int SCAN_ROWS = 4;

    typedef enum logic [1:0] {PH_SETTLE, PH_CHECK, PH_RELEASE, PH_GAP} t_scan_phase;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_stall_mode;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             done;
        logic             busy;
        logic [3:0]       cols;
    } t_scan_result;

    typedef struct packed {
        logic       cmd;
        logic [3:0] rows;
    } t_key_word;

    localparam logic [KEY_W-1:0] KEYPAD_ASCII [SCAN_COLS][SCAN_ROWS] = '{
        '{"1", "4", "7", "*"},
        '{"2", "5", "8", "0"},
        '{"3", "6", "9", "#"},
        '{"A", "B", "C", "D"}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata = '0;   // row_lines[3:0], zero pad
    logic                s_axis_tuser = CMD_TICK;  // command
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // column_drive[3:0], busy_res[4], done_res[5], key_code[13:6], zero pad
    logic [OUT_DW-1:0]   m_axis_tdata;
    logic                i_cfg_we = 1'b0;
    t_cfg_idx            i_cfg_idx = CFG_TIMEOUT;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    matrix_keypad_scanner_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // scanner model state
    logic [CFG_W-1:0] cfg_timeout = 8'd0;
    logic [CFG_W-1:0] cfg_settle  = SETTLE_RESET;
    logic [CFG_W-1:0] cfg_gap     = GAP_RESET;
    logic             searching   = 1'b0;
    t_scan_phase      ph          = PH_SETTLE;
    logic [1:0]       col         = '0;
    logic [1:0]       row         = '0;
    logic [7:0]       ticks       = '0;
    logic [7:0]       elapsed     = '0;
    logic [KEY_W-1:0] found       = KEY_NONE;

    t_key_word    key_word_q[$];
    t_scan_result expected_scan_q[$];
    int           errors = 0;
    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;
    t_scan_result drv_res;
    t_key_word    drv_word;
    t_scan_result mon_want;
    t_scan_result mon_got;

    task automatic start_column(input int c);
        col   = 2'(c);
        row   = '0;
        ticks = '0;
        ph    = PH_SETTLE;
    endtask

    task automatic advance_row();
        if (int'(row) + 1 < SCAN_ROWS) begin
            row = row + 2'd1;
            ph  = PH_CHECK;
        end else if (int'(col) + 1 < SCAN_COLS) begin
            start_column(int'(col) + 1);
        end else begin
            ticks = '0;
            ph    = PH_GAP;
        end
    endtask

    task automatic scan_step(input logic cmd, input logic [3:0] rows,
                             output t_scan_result res);
        logic             done;
        logic [KEY_W-1:0] code;
        int               sum;
        done = 1'b0;
        code = KEY_NONE;
        if (cmd == CMD_START) begin
            searching = 1'b1;
            elapsed   = '0;
            found     = KEY_NONE;
            start_column(0);
        end else if (searching) begin
            case (ph)
                PH_SETTLE: begin
                    if (ticks < CNT_MAX) ticks = ticks + 8'd1;
                    if (ticks >= cfg_settle) begin
                        ticks = '0;
                        row   = '0;
                        ph    = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (!rows[row]) ph = PH_RELEASE;
                    else advance_row();
                end
                PH_RELEASE: begin
                    if (rows[row]) begin
                        found = KEYPAD_ASCII[col][row];
                        advance_row();
                    end
                end
                default: begin
                    if (ticks < CNT_MAX) ticks = ticks + 8'd1;
                    if (ticks >= cfg_gap) begin
                        sum     = int'(elapsed) + int'(cfg_gap);
                        elapsed = (sum > 255) ? CNT_MAX : 8'(sum);
                        if (found != KEY_NONE) begin
                            done = 1'b1;
                            code = found;
                        end else if (cfg_timeout != 0 && elapsed >= cfg_timeout) begin
                            done = 1'b1;
                            code = KEY_TIMEOUT;
                        end
                        if (done) begin
                            searching = 1'b0;
                            ph        = PH_SETTLE;
                            col       = '0;
                            row       = '0;
                            ticks     = '0;
                        end else begin
                            start_column(0);
                        end
                    end
                end
            endcase
        end
        res.cols = searching ? ~(4'b0001 << col) : 4'hF;
        res.busy = searching;
        res.done = done;
        res.key  = done ? code : KEY_NONE;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                scan_step(s_axis_tuser, s_axis_tdata[3:0], drv_res);
                expected_scan_q.push_back(drv_res);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (key_word_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    drv_word = key_word_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= drv_word.cmd;
                    s_axis_tdata  <= {{(IN_DW-4){1'b0}}, drv_word.rows};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                mon_got.cols = m_axis_tdata[3:0];
                mon_got.busy = m_axis_tdata[4];
                mon_got.done = m_axis_tdata[5];
                mon_got.key  = m_axis_tdata[13:6];
                if (expected_scan_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    mon_want = expected_scan_q.pop_front();
                    check_field("column_drive", int'(mon_want.cols), int'(mon_got.cols));
                    check_field("busy_res", int'(mon_want.busy), int'(mon_got.busy));
                    check_field("done_res", int'(mon_want.done), int'(mon_got.done));
                    check_field("key_code", int'(mon_want.key), int'(mon_got.key));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TIMEOUT: cfg_timeout = val;
            CFG_SETTLE:  cfg_settle  = val;
            CFG_GAP:     cfg_gap     = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input int tmo, input int settle, input int gap);
        write_reg(CFG_TIMEOUT, 8'(tmo));
        write_reg(CFG_SETTLE, 8'(settle));
        write_reg(CFG_GAP, 8'(gap));
    endtask

    task automatic set_mode(input t_stall_mode mode);
        send_gap_pct   = (mode == IDLE_SEND) ? 77 : (mode == IDLE_BOTH) ? 8 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 77 : (mode == IDLE_BOTH) ? 8 : 0;
    endtask

    task automatic queue_word(input logic cmd, input logic [3:0] rows);
        t_key_word w;
        w.cmd  = cmd;
        w.rows = rows;
        key_word_q.push_back(w);
    endtask

    function automatic logic [3:0] sample_rows(input int press_pct);
        return ($urandom_range(0, 99) < press_pct) ? 4'($urandom) : 4'hF;
    endfunction

    // start, then ticks with random presses and the odd restart
    task automatic queue_search(input int n_ticks, input int press_pct);
        queue_word(CMD_START, 4'($urandom));
        for (int i = 0; i < n_ticks; i++) begin
            if ($urandom_range(0, 99) < 2) queue_word(CMD_START, 4'($urandom));
            else queue_word(CMD_TICK, sample_rows(press_pct));
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (key_word_q.size() != 0 || s_axis_tvalid || expected_scan_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: idle ticks, then one search at the default timing
        set_mode(IDLE_NONE);
        queue_word(CMD_TICK, 4'h0);
        queue_word(CMD_TICK, 4'hF);
        queue_search(130, 3);
        drain();

        // directed: two keys in column 0, the later one wins
        set_config(1, 1, 1);
        queue_word(CMD_TICK, 4'h0);
        queue_word(CMD_START, 4'hF);
        queue_word(CMD_TICK, 4'hF);
        queue_word(CMD_START, 4'h0);
        queue_word(CMD_TICK, 4'hF);
        queue_word(CMD_TICK, 4'hE);
        queue_word(CMD_TICK, 4'h0);
        queue_word(CMD_TICK, 4'hF);
        queue_word(CMD_TICK, 4'hB);
        queue_word(CMD_TICK, 4'hD);
        queue_word(CMD_TICK, 4'h7);
        queue_word(CMD_TICK, 4'h7);
        queue_word(CMD_TICK, 4'hF);
        for (int i = 0; i < 17; i++) queue_word(CMD_TICK, 4'hF);
        drain();

        // zero settle and gap behave as one tick
        set_mode(IDLE_SEND);
        set_config(2, 0, 0);
        for (int i = 0; i < 2; i++) queue_search(30, $urandom_range(0, 15));
        drain();

        // elapsed saturates across two long gaps, then full timeout
        set_mode(IDLE_RECV);
        set_config(255, 1, 128);
        queue_word(CMD_START, 4'hF);
        for (int i = 0; i < 300; i++) queue_word(CMD_TICK, 4'hF);
        drain();

        for (int k = 0; k < 8; k++) begin
            set_mode(t_stall_mode'(k % 4));
            case ($urandom_range(0, 3))
                0: set_config(0, $urandom_range(1, 4), $urandom_range(1, 4));
                1: set_config(255, $urandom_range(1, 4), $urandom_range(1, 4));
                default: set_config($urandom_range(1, 12), $urandom_range(1, 4),
                                    $urandom_range(1, 4));
            endcase
            while (key_word_q.size() < 30)
                queue_search($urandom_range(15, 60), $urandom_range(0, 30));
            for (int i = 0; i < 10; i++)
                queue_word($urandom_range(0, 99) < 10 ? CMD_START : CMD_TICK, 4'($urandom));
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0 && expected_scan_q.size() == 0) begin
            $display("matrix_keypad_scanner_core_tb OK");
        end else begin
            $display("matrix_keypad_scanner_core_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("matrix_keypad_scanner_core_tb NOT OK");
        $finish;
    end

endmodule
